// ===== hdl/aos_pkg.sv =====
// Shared types, constants and the step programs of the attractor orbit step block.
package aos_pkg;

  // Number format and unit sizes.
  localparam int FRAC_BITS  = 20;
  localparam int TRIG_STEPS = 24;
  localparam int WORD_W     = 32;
  localparam int ACC_W      = 36;
  localparam int CORDIC_W   = 34;
  localparam int Z_W        = 33;
  localparam int ATAN_W     = 30;
  localparam int K_W        = 5;
  localparam int PC_W       = 5;
  localparam int ESC_W      = 40;
  localparam int TRIG_SHIFT = 30 - FRAC_BITS;

  localparam logic signed [WORD_W-1:0] INV_TWO_PI   = 32'sd683565276;
  localparam logic signed [WORD_W-1:0] CORDIC_GAIN  = 32'sd652032874;
  localparam logic signed [WORD_W-1:0] POINT_RESET  = WORD_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [ESC_W-1:0]  ESC_LIMIT    = ESC_W'(100) << FRAC_BITS;

  // Reset values of the configuration registers.
  localparam logic signed [WORD_W-1:0] COEF_A_RESET = -32'sd1468006;
  localparam logic signed [WORD_W-1:0] COEF_B_RESET = 32'sd1677722;
  localparam logic signed [WORD_W-1:0] COEF_C_RESET = 32'sd1048576;
  localparam logic signed [WORD_W-1:0] COEF_D_RESET = 32'sd734003;
  localparam logic signed [WORD_W-1:0] OMEGA_RESET  = 32'sd1048576;
  localparam logic [WORD_W-2:0]        DT_RESET     = 31'd52429;

  // Item types.
  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] start_x;
    logic signed [WORD_W-1:0] start_y;
    logic signed [WORD_W-1:0] start_time;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic                     escaped;
  } out_item_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MAP_MODE  = 3'd0,
    CFG_COEF_A    = 3'd1,
    CFG_COEF_B    = 3'd2,
    CFG_COEF_C    = 3'd3,
    CFG_COEF_D    = 3'd4,
    CFG_OMEGA     = 3'd5,
    CFG_TIME_STEP = 3'd6
  } cfg_idx_e;

  // Map selection codes.
  typedef enum logic [2:0] {
    MODE_CLIFFORD   = 3'd0,
    MODE_DE_JONG    = 3'd1,
    MODE_TINKERBELL = 3'd2,
    MODE_DUFFING    = 3'd3,
    MODE_SVENSSON   = 3'd4,
    MODE_BEDHEAD    = 3'd5
  } map_mode_e;

  // Step program instructions.
  typedef enum logic [2:0] {
    UOP_END  = 3'd0,
    UOP_MUL  = 3'd1,
    UOP_TRIG = 3'd2,
    UOP_CLR  = 3'd3,
    UOP_ADD  = 3'd4,
    UOP_SUB  = 3'd5,
    UOP_SAT  = 3'd6
  } uop_op_e;

  typedef enum logic [3:0] {
    SRC_X   = 4'd0,
    SRC_Y   = 4'd1,
    SRC_T   = 4'd2,
    SRC_A   = 4'd3,
    SRC_B   = 4'd4,
    SRC_C   = 4'd5,
    SRC_D   = 4'd6,
    SRC_W   = 4'd7,
    SRC_DT  = 4'd8,
    SRC_T0  = 4'd9,
    SRC_T1  = 4'd10,
    SRC_SIN = 4'd11,
    SRC_COS = 4'd12
  } src_e;

  typedef enum logic [2:0] {
    DST_T0 = 3'd0,
    DST_T1 = 3'd1,
    DST_NX = 3'd2,
    DST_NY = 3'd3,
    DST_NT = 3'd4
  } dst_e;

  typedef struct packed {
    uop_op_e op;
    src_e    src_a;
    src_e    src_b;
    dst_e    dst;
  } uop_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    DP_NOP    = 4'd0,
    DP_LOAD   = 4'd1,
    DP_BEGIN  = 4'd2,
    DP_MULP   = 4'd3,
    DP_TRIGP  = 4'd4,
    DP_MULW   = 4'd5,
    DP_CLR    = 4'd6,
    DP_ADD    = 4'd7,
    DP_SUB    = 4'd8,
    DP_SAT    = 4'd9,
    DP_CINIT  = 4'd10,
    DP_CITER  = 4'd11,
    DP_CFIN   = 4'd12,
    DP_COMMIT = 4'd13
  } dp_op_e;

  typedef struct packed {
    dp_op_e         op;
    src_e           src_a;
    src_e           src_b;
    dst_e           dst;
    logic [K_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] map_mode;
  } dp_status_t;

  // Saturate a wide value to one word.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat_word = hi[WORD_W-1:0];
    end else if (v < lo) begin
      sat_word = lo[WORD_W-1:0];
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

  // Arctangent of 2^-k in binary angle units of 2^32 per turn.
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [K_W-1:0] k);
    case (k)
      5'd0:  atan_turn = 30'h20000000;
      5'd1:  atan_turn = 30'h12E4051E;
      5'd2:  atan_turn = 30'h09FB385B;
      5'd3:  atan_turn = 30'h051111D4;
      5'd4:  atan_turn = 30'h028B0D43;
      5'd5:  atan_turn = 30'h0145D7E1;
      5'd6:  atan_turn = 30'h00A2F61E;
      5'd7:  atan_turn = 30'h00517C55;
      5'd8:  atan_turn = 30'h0028BE53;
      5'd9:  atan_turn = 30'h00145F2F;
      5'd10: atan_turn = 30'h000A2F98;
      5'd11: atan_turn = 30'h000517CC;
      5'd12: atan_turn = 30'h00028BE6;
      5'd13: atan_turn = 30'h000145F3;
      5'd14: atan_turn = 30'h0000A2FA;
      5'd15: atan_turn = 30'h0000517D;
      5'd16: atan_turn = 30'h000028BE;
      5'd17: atan_turn = 30'h0000145F;
      5'd18: atan_turn = 30'h00000A30;
      5'd19: atan_turn = 30'h00000518;
      5'd20: atan_turn = 30'h0000028C;
      5'd21: atan_turn = 30'h00000146;
      5'd22: atan_turn = 30'h000000A3;
      5'd23: atan_turn = 30'h00000051;
      5'd24: atan_turn = 30'h00000029;
      5'd25: atan_turn = 30'h00000014;
      5'd26: atan_turn = 30'h0000000A;
      5'd27: atan_turn = 30'h00000005;
      5'd28: atan_turn = 30'h00000003;
      5'd29: atan_turn = 30'h00000001;
      5'd30: atan_turn = 30'h00000001;
      default: atan_turn = 30'h00000000;
    endcase
  endfunction

  function automatic uop_t mk(input uop_op_e op, input src_e a, input src_e b,
                              input dst_e d);
    uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    mk = u;
  endfunction

  // Step programs, one per map. Unused modes run straight to the end.
  function automatic uop_t uop_fetch(input logic [2:0] mode, input logic [PC_W-1:0] pc);
    uop_t u;
    u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
    case (mode)
      MODE_CLIFFORD: begin
        case (pc)
          5'd0:  u = mk(UOP_MUL,  SRC_A,   SRC_Y, DST_T0);
          5'd1:  u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd2:  u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd3:  u = mk(UOP_ADD,  SRC_SIN, SRC_X, DST_T0);
          5'd4:  u = mk(UOP_MUL,  SRC_A,   SRC_X, DST_T0);
          5'd5:  u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd6:  u = mk(UOP_MUL,  SRC_C,   SRC_COS, DST_T0);
          5'd7:  u = mk(UOP_ADD,  SRC_T0,  SRC_X, DST_T0);
          5'd8:  u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_NX);
          5'd9:  u = mk(UOP_MUL,  SRC_B,   SRC_X, DST_T0);
          5'd10: u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd11: u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd12: u = mk(UOP_ADD,  SRC_SIN, SRC_X, DST_T0);
          5'd13: u = mk(UOP_MUL,  SRC_B,   SRC_Y, DST_T0);
          5'd14: u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd15: u = mk(UOP_MUL,  SRC_D,   SRC_COS, DST_T0);
          5'd16: u = mk(UOP_ADD,  SRC_T0,  SRC_X, DST_T0);
          5'd17: u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_NY);
          default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
        endcase
      end
      MODE_DE_JONG: begin
        case (pc)
          5'd0:  u = mk(UOP_MUL,  SRC_A,   SRC_Y, DST_T0);
          5'd1:  u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd2:  u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd3:  u = mk(UOP_ADD,  SRC_SIN, SRC_X, DST_T0);
          5'd4:  u = mk(UOP_MUL,  SRC_B,   SRC_X, DST_T0);
          5'd5:  u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd6:  u = mk(UOP_SUB,  SRC_COS, SRC_X, DST_T0);
          5'd7:  u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_NX);
          5'd8:  u = mk(UOP_MUL,  SRC_C,   SRC_X, DST_T0);
          5'd9:  u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd10: u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd11: u = mk(UOP_ADD,  SRC_SIN, SRC_X, DST_T0);
          5'd12: u = mk(UOP_MUL,  SRC_D,   SRC_Y, DST_T0);
          5'd13: u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd14: u = mk(UOP_SUB,  SRC_COS, SRC_X, DST_T0);
          5'd15: u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_NY);
          default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
        endcase
      end
      MODE_TINKERBELL: begin
        case (pc)
          5'd0:  u = mk(UOP_CLR, SRC_X,  SRC_X, DST_T0);
          5'd1:  u = mk(UOP_MUL, SRC_X,  SRC_X, DST_T0);
          5'd2:  u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd3:  u = mk(UOP_MUL, SRC_Y,  SRC_Y, DST_T0);
          5'd4:  u = mk(UOP_SUB, SRC_T0, SRC_X, DST_T0);
          5'd5:  u = mk(UOP_MUL, SRC_A,  SRC_X, DST_T0);
          5'd6:  u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd7:  u = mk(UOP_MUL, SRC_B,  SRC_Y, DST_T0);
          5'd8:  u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd9:  u = mk(UOP_SAT, SRC_X,  SRC_X, DST_NX);
          5'd10: u = mk(UOP_CLR, SRC_X,  SRC_X, DST_T0);
          5'd11: u = mk(UOP_MUL, SRC_X,  SRC_Y, DST_T0);
          5'd12: u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd13: u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd14: u = mk(UOP_MUL, SRC_C,  SRC_X, DST_T0);
          5'd15: u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd16: u = mk(UOP_MUL, SRC_D,  SRC_Y, DST_T0);
          5'd17: u = mk(UOP_ADD, SRC_T0, SRC_X, DST_T0);
          5'd18: u = mk(UOP_SAT, SRC_X,  SRC_X, DST_NY);
          default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
        endcase
      end
      MODE_DUFFING: begin
        case (pc)
          5'd0:  u = mk(UOP_CLR,  SRC_X,  SRC_X,   DST_T0);
          5'd1:  u = mk(UOP_MUL,  SRC_C,  SRC_Y,   DST_T0);
          5'd2:  u = mk(UOP_SUB,  SRC_T0, SRC_X,   DST_T0);
          5'd3:  u = mk(UOP_MUL,  SRC_A,  SRC_X,   DST_T0);
          5'd4:  u = mk(UOP_SUB,  SRC_T0, SRC_X,   DST_T0);
          5'd5:  u = mk(UOP_MUL,  SRC_X,  SRC_X,   DST_T0);
          5'd6:  u = mk(UOP_MUL,  SRC_T0, SRC_X,   DST_T0);
          5'd7:  u = mk(UOP_MUL,  SRC_B,  SRC_T0,  DST_T0);
          5'd8:  u = mk(UOP_SUB,  SRC_T0, SRC_X,   DST_T0);
          5'd9:  u = mk(UOP_MUL,  SRC_W,  SRC_T,   DST_T0);
          5'd10: u = mk(UOP_TRIG, SRC_T0, SRC_X,   DST_T0);
          5'd11: u = mk(UOP_MUL,  SRC_D,  SRC_COS, DST_T0);
          5'd12: u = mk(UOP_ADD,  SRC_T0, SRC_X,   DST_T0);
          5'd13: u = mk(UOP_SAT,  SRC_X,  SRC_X,   DST_T1);
          5'd14: u = mk(UOP_CLR,  SRC_X,  SRC_X,   DST_T0);
          5'd15: u = mk(UOP_MUL,  SRC_Y,  SRC_DT,  DST_T0);
          5'd16: u = mk(UOP_ADD,  SRC_T0, SRC_X,   DST_T0);
          5'd17: u = mk(UOP_ADD,  SRC_X,  SRC_X,   DST_T0);
          5'd18: u = mk(UOP_SAT,  SRC_X,  SRC_X,   DST_NX);
          5'd19: u = mk(UOP_CLR,  SRC_X,  SRC_X,   DST_T0);
          5'd20: u = mk(UOP_MUL,  SRC_T1, SRC_DT,  DST_T0);
          5'd21: u = mk(UOP_ADD,  SRC_T0, SRC_X,   DST_T0);
          5'd22: u = mk(UOP_ADD,  SRC_Y,  SRC_X,   DST_T0);
          5'd23: u = mk(UOP_SAT,  SRC_X,  SRC_X,   DST_NY);
          5'd24: u = mk(UOP_CLR,  SRC_X,  SRC_X,   DST_T0);
          5'd25: u = mk(UOP_ADD,  SRC_T,  SRC_X,   DST_T0);
          5'd26: u = mk(UOP_ADD,  SRC_DT, SRC_X,   DST_T0);
          5'd27: u = mk(UOP_SAT,  SRC_X,  SRC_X,   DST_NT);
          default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
        endcase
      end
      MODE_SVENSSON: begin
        case (pc)
          5'd0:  u = mk(UOP_CLR,  SRC_X,   SRC_X,   DST_T0);
          5'd1:  u = mk(UOP_MUL,  SRC_A,   SRC_X,   DST_T0);
          5'd2:  u = mk(UOP_TRIG, SRC_T0,  SRC_X,   DST_T0);
          5'd3:  u = mk(UOP_MUL,  SRC_D,   SRC_SIN, DST_T1);
          5'd4:  u = mk(UOP_ADD,  SRC_T1,  SRC_X,   DST_T0);
          5'd5:  u = mk(UOP_MUL,  SRC_C,   SRC_COS, DST_T1);
          5'd6:  u = mk(UOP_MUL,  SRC_B,   SRC_Y,   DST_T0);
          5'd7:  u = mk(UOP_TRIG, SRC_T0,  SRC_X,   DST_T0);
          5'd8:  u = mk(UOP_SUB,  SRC_SIN, SRC_X,   DST_T0);
          5'd9:  u = mk(UOP_SAT,  SRC_X,   SRC_X,   DST_NX);
          5'd10: u = mk(UOP_CLR,  SRC_X,   SRC_X,   DST_T0);
          5'd11: u = mk(UOP_ADD,  SRC_T1,  SRC_X,   DST_T0);
          5'd12: u = mk(UOP_ADD,  SRC_COS, SRC_X,   DST_T0);
          5'd13: u = mk(UOP_SAT,  SRC_X,   SRC_X,   DST_NY);
          default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
        endcase
      end
      MODE_BEDHEAD: begin
        case (pc)
          5'd0:  u = mk(UOP_MUL,  SRC_A,   SRC_X, DST_T0);
          5'd1:  u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd2:  u = mk(UOP_ADD,  SRC_T0,  SRC_X, DST_T0);
          5'd3:  u = mk(UOP_SUB,  SRC_Y,   SRC_X, DST_T0);
          5'd4:  u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_T1);
          5'd5:  u = mk(UOP_TRIG, SRC_T1,  SRC_X, DST_T0);
          5'd6:  u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd7:  u = mk(UOP_ADD,  SRC_COS, SRC_X, DST_T0);
          5'd8:  u = mk(UOP_MUL,  SRC_X,   SRC_Y, DST_T0);
          5'd9:  u = mk(UOP_MUL,  SRC_T0,  SRC_B, DST_T0);
          5'd10: u = mk(UOP_TRIG, SRC_T0,  SRC_X, DST_T0);
          5'd11: u = mk(UOP_MUL,  SRC_SIN, SRC_Y, DST_T0);
          5'd12: u = mk(UOP_ADD,  SRC_T0,  SRC_X, DST_T0);
          5'd13: u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_NX);
          5'd14: u = mk(UOP_CLR,  SRC_X,   SRC_X, DST_T0);
          5'd15: u = mk(UOP_ADD,  SRC_X,   SRC_X, DST_T0);
          5'd16: u = mk(UOP_TRIG, SRC_Y,   SRC_X, DST_T0);
          5'd17: u = mk(UOP_MUL,  SRC_SIN, SRC_B, DST_T0);
          5'd18: u = mk(UOP_ADD,  SRC_T0,  SRC_X, DST_T0);
          5'd19: u = mk(UOP_SAT,  SRC_X,   SRC_X, DST_NY);
          default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
        endcase
      end
      default: u = mk(UOP_END, SRC_X, SRC_X, DST_T0);
    endcase
    uop_fetch = u;
  endfunction

endpackage

// ===== hdl/attractor_orbit_step_top.sv =====
// Top level of the attractor orbit step block.
// Usage:
// The block holds one orbit point, a time phase for the Duffing map and a
// sticky escape flag. Configuration writes on cfg_* (index, data) set the map
// mode and the coefficients; the port is always ready, and the user must write it
// only while no item is in progress; the block itself does not enforce this.
// An input item with kind set loads the start point and produces no result.
// An input item with kind clear runs one map step and produces one output
// item with the new point and the escape flag.
// A step runs its map's program one instruction after another: each multiply
// forms the product and then writes it back, each sine and cosine pair runs on
// the shared CORDIC unit (reduction, setup, 24 rotations and fold), and the step
// ends with a finish and a commit.
// One step is in flight at a time: the next item is accepted once the
// previous step has committed. A finished result waits in the output
// register; a stalled receiver holds only the commit of the following step.
// Reset restores the coefficient defaults, the start point 0.1, 0.1 and a
// clear escape flag, and drops any pending output.
module attractor_orbit_step_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  aos_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output aos_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [aos_pkg::WORD_W-1:0]  cfg_data_i
);

  aos_pkg::dp_cmd_t    cmd;
  aos_pkg::dp_status_t status;

  // Sequencer.
  aos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  aos_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/aos_ctrl.sv =====
// Controller: handshakes, step program counter and datapath command sequencing.
module aos_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  aos_pkg::dp_status_t  status_i,
  output aos_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FETCH  = 7'b0000010,
    ST_MULW   = 7'b0000100,
    ST_CINIT  = 7'b0001000,
    ST_CITER  = 7'b0010000,
    ST_CFIN   = 7'b0100000,
    ST_COMMIT = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  logic [aos_pkg::PC_W-1:0]    pc_q, pc_d;
  logic [aos_pkg::K_W-1:0]     k_q, k_d;
  logic                        out_valid_q, out_valid_d;
  aos_pkg::uop_t               uop;

  // Current instruction of the running program.
  assign uop = aos_pkg::uop_fetch(status_i.map_mode, pc_q);

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = aos_pkg::DP_NOP;
    cmd_o.src_a = uop.src_a;
    cmd_o.src_b = uop.src_b;
    cmd_o.dst   = uop.dst;
    cmd_o.k     = k_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i) begin
            cmd_o.op = aos_pkg::DP_LOAD;
          end else begin
            cmd_o.op = aos_pkg::DP_BEGIN;
            pc_d     = '0;
            state_d  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        case (uop.op)
          aos_pkg::UOP_MUL: begin
            cmd_o.op = aos_pkg::DP_MULP;
            state_d  = ST_MULW;
          end
          aos_pkg::UOP_TRIG: begin
            cmd_o.op = aos_pkg::DP_TRIGP;
            state_d  = ST_CINIT;
          end
          aos_pkg::UOP_CLR: begin
            cmd_o.op = aos_pkg::DP_CLR;
            pc_d     = pc_q + 1'b1;
          end
          aos_pkg::UOP_ADD: begin
            cmd_o.op = aos_pkg::DP_ADD;
            pc_d     = pc_q + 1'b1;
          end
          aos_pkg::UOP_SUB: begin
            cmd_o.op = aos_pkg::DP_SUB;
            pc_d     = pc_q + 1'b1;
          end
          aos_pkg::UOP_SAT: begin
            cmd_o.op = aos_pkg::DP_SAT;
            pc_d     = pc_q + 1'b1;
          end
          default: begin
            state_d = ST_COMMIT;
          end
        endcase
      end
      ST_MULW: begin
        cmd_o.op = aos_pkg::DP_MULW;
        pc_d     = pc_q + 1'b1;
        state_d  = ST_FETCH;
      end
      ST_CINIT: begin
        cmd_o.op = aos_pkg::DP_CINIT;
        k_d      = '0;
        state_d  = ST_CITER;
      end
      ST_CITER: begin
        cmd_o.op = aos_pkg::DP_CITER;
        if (k_q == aos_pkg::K_W'(aos_pkg::TRIG_STEPS - 1)) begin
          state_d = ST_CFIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_CFIN: begin
        cmd_o.op = aos_pkg::DP_CFIN;
        pc_d     = pc_q + 1'b1;
        state_d  = ST_FETCH;
      end
      ST_COMMIT: begin
        // Wait until the output register is free, then publish the point.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = aos_pkg::DP_COMMIT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/aos_dp.sv =====
// Datapath: configuration, orbit state, multiplier, accumulator and CORDIC unit.
module aos_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [aos_pkg::WORD_W-1:0]  cfg_data_i,
  input  aos_pkg::in_item_t           in_item_i,
  input  aos_pkg::dp_cmd_t            cmd_i,
  output aos_pkg::dp_status_t         status_o,
  output aos_pkg::out_item_t          out_item_o
);

  localparam int W  = aos_pkg::WORD_W;
  localparam int CW = aos_pkg::CORDIC_W;
  localparam int ZW = aos_pkg::Z_W;

  // Configuration registers.
  logic [2:0]          mode_q;
  logic signed [W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, omega_q;
  logic [W-2:0]        dt_q;

  // Orbit state.
  logic signed [W-1:0] x_q, y_q, t_q;
  logic                esc_q;

  // Working registers.
  logic signed [W-1:0]             t0_q, t1_q, nx_q, ny_q, nt_q, sin_q, cos_q;
  logic signed [aos_pkg::ACC_W-1:0] acc_q;
  logic signed [63:0]              prod_q;
  logic signed [ZW-1:0]            z_q;
  logic signed [CW-1:0]            cx_q, cy_q;
  logic [1:0]                      quad_q;
  aos_pkg::out_item_t              out_q;

  logic signed [W-1:0]  op_a, op_b, mul_b, mulw_res, sat_res, dt_word;
  logic signed [63:0]   prod_d;
  logic [W-1:0]         phase;
  logic signed [CW-1:0] dx, dy, fold_s, fold_c, sh_s, sh_c;
  logic signed [ZW-1:0] atan_z;
  logic signed [aos_pkg::ESC_W-1:0] nx_ext, ny_ext;
  logic                 esc_d;

  assign cfg_ready_o       = 1'b1;
  assign status_o.map_mode = mode_q;
  assign out_item_o        = out_q;
  assign dt_word           = W'({1'b0, dt_q});

  // Operand selection.
  always_comb begin
    case (cmd_i.src_a)
      aos_pkg::SRC_X:   op_a = x_q;
      aos_pkg::SRC_Y:   op_a = y_q;
      aos_pkg::SRC_T:   op_a = t_q;
      aos_pkg::SRC_A:   op_a = coef_a_q;
      aos_pkg::SRC_B:   op_a = coef_b_q;
      aos_pkg::SRC_C:   op_a = coef_c_q;
      aos_pkg::SRC_D:   op_a = coef_d_q;
      aos_pkg::SRC_W:   op_a = omega_q;
      aos_pkg::SRC_DT:  op_a = dt_word;
      aos_pkg::SRC_T0:  op_a = t0_q;
      aos_pkg::SRC_T1:  op_a = t1_q;
      aos_pkg::SRC_SIN: op_a = sin_q;
      aos_pkg::SRC_COS: op_a = cos_q;
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.src_b)
      aos_pkg::SRC_X:   op_b = x_q;
      aos_pkg::SRC_Y:   op_b = y_q;
      aos_pkg::SRC_T:   op_b = t_q;
      aos_pkg::SRC_A:   op_b = coef_a_q;
      aos_pkg::SRC_B:   op_b = coef_b_q;
      aos_pkg::SRC_C:   op_b = coef_c_q;
      aos_pkg::SRC_D:   op_b = coef_d_q;
      aos_pkg::SRC_W:   op_b = omega_q;
      aos_pkg::SRC_DT:  op_b = dt_word;
      aos_pkg::SRC_T0:  op_b = t0_q;
      aos_pkg::SRC_T1:  op_b = t1_q;
      aos_pkg::SRC_SIN: op_b = sin_q;
      aos_pkg::SRC_COS: op_b = cos_q;
      default:          op_b = '0;
    endcase
  end

  // Shared multiplier; angle reduction multiplies by one over two pi.
  assign mul_b    = (cmd_i.op == aos_pkg::DP_TRIGP) ? aos_pkg::INV_TWO_PI : op_b;
  assign prod_d   = 64'(op_a) * 64'(mul_b);
  assign mulw_res = aos_pkg::sat_word(prod_q >>> aos_pkg::FRAC_BITS);
  assign sat_res  = aos_pkg::sat_word(64'(acc_q));

  // Angle in binary units: the quadrant goes apart, the rest feeds the CORDIC.
  assign phase = prod_q[aos_pkg::FRAC_BITS +: W];

  // One CORDIC rotation.
  assign dx     = cy_q >>> cmd_i.k;
  assign dy     = cx_q >>> cmd_i.k;
  assign atan_z = ZW'(aos_pkg::atan_turn(cmd_i.k));

  // Quadrant fold and scaling down to the word format.
  always_comb begin
    case (quad_q)
      2'd0: begin
        fold_c = cx_q;
        fold_s = cy_q;
      end
      2'd1: begin
        fold_c = -cy_q;
        fold_s = cx_q;
      end
      2'd2: begin
        fold_c = -cx_q;
        fold_s = -cy_q;
      end
      default: begin
        fold_c = cy_q;
        fold_s = -cx_q;
      end
    endcase
    sh_c = fold_c >>> aos_pkg::TRIG_SHIFT;
    sh_s = fold_s >>> aos_pkg::TRIG_SHIFT;
  end

  // Escape test on the point being committed.
  assign nx_ext = aos_pkg::ESC_W'(nx_q);
  assign ny_ext = aos_pkg::ESC_W'(ny_q);
  assign esc_d  = esc_q || (nx_ext > aos_pkg::ESC_LIMIT) || (nx_ext < -aos_pkg::ESC_LIMIT)
                  || (ny_ext > aos_pkg::ESC_LIMIT) || (ny_ext < -aos_pkg::ESC_LIMIT);

  // Configuration and orbit state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= aos_pkg::MODE_CLIFFORD;
      coef_a_q <= aos_pkg::COEF_A_RESET;
      coef_b_q <= aos_pkg::COEF_B_RESET;
      coef_c_q <= aos_pkg::COEF_C_RESET;
      coef_d_q <= aos_pkg::COEF_D_RESET;
      omega_q  <= aos_pkg::OMEGA_RESET;
      dt_q     <= aos_pkg::DT_RESET;
      x_q      <= aos_pkg::POINT_RESET;
      y_q      <= aos_pkg::POINT_RESET;
      t_q      <= '0;
      esc_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          aos_pkg::CFG_MAP_MODE:  mode_q   <= cfg_data_i[2:0];
          aos_pkg::CFG_COEF_A:    coef_a_q <= cfg_data_i;
          aos_pkg::CFG_COEF_B:    coef_b_q <= cfg_data_i;
          aos_pkg::CFG_COEF_C:    coef_c_q <= cfg_data_i;
          aos_pkg::CFG_COEF_D:    coef_d_q <= cfg_data_i;
          aos_pkg::CFG_OMEGA:     omega_q  <= cfg_data_i;
          aos_pkg::CFG_TIME_STEP: dt_q     <= cfg_data_i[W-2:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == aos_pkg::DP_LOAD) begin
        x_q   <= in_item_i.start_x;
        y_q   <= in_item_i.start_y;
        t_q   <= in_item_i.start_time;
        esc_q <= 1'b0;
      end else if (cmd_i.op == aos_pkg::DP_COMMIT) begin
        x_q   <= nx_q;
        y_q   <= ny_q;
        t_q   <= nt_q;
        esc_q <= esc_d;
      end
    end
  end

  // Working registers of the step.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      aos_pkg::DP_BEGIN: begin
        nx_q <= x_q;
        ny_q <= y_q;
        nt_q <= t_q;
      end
      aos_pkg::DP_MULP, aos_pkg::DP_TRIGP: begin
        prod_q <= prod_d;
      end
      aos_pkg::DP_MULW, aos_pkg::DP_SAT: begin
        case (cmd_i.dst)
          aos_pkg::DST_T0: t0_q <= (cmd_i.op == aos_pkg::DP_SAT) ? sat_res : mulw_res;
          aos_pkg::DST_T1: t1_q <= (cmd_i.op == aos_pkg::DP_SAT) ? sat_res : mulw_res;
          aos_pkg::DST_NX: nx_q <= (cmd_i.op == aos_pkg::DP_SAT) ? sat_res : mulw_res;
          aos_pkg::DST_NY: ny_q <= (cmd_i.op == aos_pkg::DP_SAT) ? sat_res : mulw_res;
          aos_pkg::DST_NT: nt_q <= (cmd_i.op == aos_pkg::DP_SAT) ? sat_res : mulw_res;
          default: begin
          end
        endcase
      end
      aos_pkg::DP_CLR: begin
        acc_q <= '0;
      end
      aos_pkg::DP_ADD: begin
        acc_q <= acc_q + aos_pkg::ACC_W'(op_a);
      end
      aos_pkg::DP_SUB: begin
        acc_q <= acc_q - aos_pkg::ACC_W'(op_a);
      end
      aos_pkg::DP_CINIT: begin
        quad_q <= phase[W-1:W-2];
        z_q    <= ZW'(phase[W-3:0]);
        cx_q   <= CW'(aos_pkg::CORDIC_GAIN);
        cy_q   <= '0;
      end
      aos_pkg::DP_CITER: begin
        if (!z_q[ZW-1]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - atan_z;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + atan_z;
        end
      end
      aos_pkg::DP_CFIN: begin
        sin_q <= sh_s[W-1:0];
        cos_q <= sh_c[W-1:0];
      end
      aos_pkg::DP_COMMIT: begin
        out_q.point_x <= nx_q;
        out_q.point_y <= ny_q;
        out_q.escaped <= esc_d;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/aos_chk.sv =====
// Port checker for the attractor orbit step block, with its bind statement.
module aos_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input aos_pkg::in_item_t           in_item_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input aos_pkg::out_item_t          out_item_o
);

  logic signed [aos_pkg::ESC_W-1:0] px, py;

  assign px = aos_pkg::ESC_W'(out_item_o.point_x);
  assign py = aos_pkg::ESC_W'(out_item_o.point_y);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // A load item produces no result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.kind && !out_valid_o |=> !out_valid_o)
    else $error("load item produced a result");

  // A result never appears in the cycle right after an item is taken.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared without a step");

  // A point beyond the escape radius carries the escape flag.
  a_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (px > aos_pkg::ESC_LIMIT || px < -aos_pkg::ESC_LIMIT ||
                    py > aos_pkg::ESC_LIMIT || py < -aos_pkg::ESC_LIMIT)
    |-> out_item_o.escaped)
    else $error("escaped point without escape flag");

endmodule

bind attractor_orbit_step_top aos_chk u_aos_chk (.*);
